### sv/thresholded_pixel_ratio_defines.svh
// assertion macros for the thresholded pixel ratio block
// included by the modules that carry concurrent checks
`ifndef THRESHOLDED_PIXEL_RATIO_DEFINES_SVH
`define THRESHOLDED_PIXEL_RATIO_DEFINES_SVH
`ifndef ASSERT_OFF
`define TPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/tpr_pkg.sv
// shared constants and types of the thresholded pixel ratio block
// no dependencies
package tpr_pkg;

  localparam int RATIO_BITS  = 16;
  localparam int THRESH_BITS = 16;
  localparam int GAIN_BITS   = 40;
  localparam int FRAC_BITS   = 16;
  localparam int ROUND_BIT   = FRAC_BITS - 1;
  localparam int FIELD_BITS  = 16;

  // quotient bits resolved per divider stage
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = RATIO_BITS / DIV_STEPS;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN      = 1'd1;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 40'd65536;

  typedef struct packed {
    logic zero;
    logic sat;
  } tpr_flags_t;

endpackage

### sv/tpr_in_if.sv
// input channel: one numerator and one denominator pixel per transaction
// depends on tpr_pkg
interface tpr_in_if;
  import tpr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] pixel_num;
  logic [FIELD_BITS-1:0] pixel_den;

  modport source (output valid, output pixel_num, output pixel_den, input ready);
  modport sink   (input valid, input pixel_num, input pixel_den, output ready);
endinterface

### sv/tpr_out_if.sv
// result channel: one ratio per transaction
// depends on tpr_pkg
interface tpr_out_if;
  import tpr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [RATIO_BITS-1:0] ratio;

  modport source (output valid, output ratio, input ready);
  modport sink   (input valid, input ratio, output ready);
endinterface

### sv/tpr_front.sv
// front stages: threshold test and gain multiply, then rounding add and overflow test
// depends on tpr_pkg and thresholded_pixel_ratio_defines.svh
`include "thresholded_pixel_ratio_defines.svh"

module tpr_front #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tpr_pkg::THRESH_BITS-1:0]  threshold,
  input  logic [tpr_pkg::GAIN_BITS-1:0]    gain,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PIXEL_BITS-1:0]            pixel_num,
  input  logic [PIXEL_BITS-1:0]            pixel_den,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tpr_pkg::tpr_flags_t              out_flags,
  output logic [PIXEL_BITS-1:0]            out_rem,
  output logic [tpr_pkg::RATIO_BITS-1:0]   out_lo,
  output logic [PIXEL_BITS-1:0]            out_den
);
  import tpr_pkg::*;

  localparam int PW = GAIN_BITS + PIXEL_BITS;
  localparam int NW = PW + 1;
  localparam int HW = NW - FRAC_BITS - RATIO_BITS;

  logic                  en1, en2;
  logic                  below;
  logic                  v1_r, v2_r;
  logic [PW-1:0]         prod1_r;
  logic [PIXEL_BITS-1:0] b1_r, b2_r;
  logic                  zero1_r;
  logic [NW-1:0]         sum2;
  logic [HW-1:0]         hi2;
  tpr_flags_t            flags2_r, flags2_nxt;
  logic [PIXEL_BITS-1:0] rem2_r;
  logic [RATIO_BITS-1:0] lo2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign below = (THRESH_BITS'(pixel_num) < threshold) || (THRESH_BITS'(pixel_den) < threshold);

  // numerator times gain plus half the divisor, both in units of 2^-16
  assign sum2 = NW'(prod1_r) + (NW'(b1_r) << ROUND_BIT);
  assign hi2  = sum2[NW-1:FRAC_BITS+RATIO_BITS];

  always_comb begin
    flags2_nxt.zero = zero1_r;
    flags2_nxt.sat  = hi2 >= HW'(b1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
    if (en1 && in_valid) begin
      prod1_r <= PW'(gain) * PW'(pixel_num);
      b1_r    <= pixel_den;
      zero1_r <= below;
    end
    if (en2 && v1_r) begin
      flags2_r <= flags2_nxt;
      rem2_r   <= hi2[PIXEL_BITS-1:0];
      lo2_r    <= sum2[FRAC_BITS+RATIO_BITS-1:FRAC_BITS];
      b2_r     <= b1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_flags = flags2_r;
  assign out_rem   = rem2_r;
  assign out_lo    = lo2_r;
  assign out_den   = b2_r;

  `TPR_ASSERT_NEXT(a_below_gives_zero, clk, rst_n, in_valid && in_ready && below, v1_r && zero1_r, "pixel below threshold not flagged")
  `TPR_ASSERT_IMP(a_rem_below_den, clk, rst_n, v2_r && !flags2_r.sat, rem2_r < b2_r, "partial remainder not below denominator")

endmodule

### sv/tpr_div.sv
// pipelined restoring divider, a few quotient bits per stage, with final select
// depends on tpr_pkg and thresholded_pixel_ratio_defines.svh
`include "thresholded_pixel_ratio_defines.svh"

module tpr_div #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tpr_pkg::tpr_flags_t              in_flags,
  input  logic [PIXEL_BITS-1:0]            in_rem,
  input  logic [tpr_pkg::RATIO_BITS-1:0]   in_lo,
  input  logic [PIXEL_BITS-1:0]            in_den,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tpr_pkg::RATIO_BITS-1:0]   out_ratio
);
  import tpr_pkg::*;

  // index 0 is the stage input, index s+1 the register of stage s
  logic                  sv   [DIV_STAGES+1];
  tpr_flags_t            sflg [DIV_STAGES+1];
  logic [PIXEL_BITS-1:0] srem [DIV_STAGES+1];
  logic [RATIO_BITS-1:0] slo  [DIV_STAGES+1];
  logic [RATIO_BITS-1:0] sq   [DIV_STAGES+1];
  logic [PIXEL_BITS-1:0] sden [DIV_STAGES+1];
  logic                  en   [DIV_STAGES+1];

  assign sv[0]   = in_valid;
  assign sflg[0] = in_flags;
  assign srem[0] = in_rem;
  assign slo[0]  = in_lo;
  assign sq[0]   = '0;
  assign sden[0] = in_den;

  assign en[DIV_STAGES] = out_ready;
  assign in_ready       = en[0];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                  v_r;
    tpr_flags_t            flg_r;
    logic [PIXEL_BITS-1:0] rem_r, rem_nxt;
    logic [RATIO_BITS-1:0] lo_r, lo_nxt;
    logic [RATIO_BITS-1:0] q_r, q_nxt;
    logic [PIXEL_BITS-1:0] den_r;

    assign en[s] = !v_r || en[s+1];

    always_comb begin
      logic [PIXEL_BITS:0] t;
      logic [PIXEL_BITS:0] d;
      rem_nxt = srem[s];
      lo_nxt  = slo[s];
      q_nxt   = sq[s];
      d       = {1'b0, sden[s]};
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {rem_nxt, lo_nxt[RATIO_BITS-1]};
        if (t >= d) begin
          t     = t - d;
          q_nxt = {q_nxt[RATIO_BITS-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[RATIO_BITS-2:0], 1'b0};
        end
        rem_nxt = t[PIXEL_BITS-1:0];
        lo_nxt  = {lo_nxt[RATIO_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en[s]) begin
        v_r <= sv[s];
      end
      if (en[s] && sv[s]) begin
        flg_r <= sflg[s];
        rem_r <= rem_nxt;
        lo_r  <= lo_nxt;
        q_r   <= q_nxt;
        den_r <= sden[s];
      end
    end

    assign sv[s+1]   = v_r;
    assign sflg[s+1] = flg_r;
    assign srem[s+1] = rem_r;
    assign slo[s+1]  = lo_r;
    assign sq[s+1]   = q_r;
    assign sden[s+1] = den_r;
  end

  assign out_valid = sv[DIV_STAGES];

  always_comb begin
    if (sflg[DIV_STAGES].zero) begin
      out_ratio = '0;
    end else if (sflg[DIV_STAGES].sat) begin
      out_ratio = '1;
    end else begin
      out_ratio = sq[DIV_STAGES];
    end
  end

  `TPR_ASSERT_IMP(a_first_rem_ok, clk, rst_n, sv[1] && !sflg[1].sat, srem[1] < sden[1], "divider remainder out of range after first stage")
  `TPR_ASSERT_IMP(a_last_rem_ok, clk, rst_n, sv[DIV_STAGES] && !sflg[DIV_STAGES].sat, srem[DIV_STAGES] < sden[DIV_STAGES], "divider remainder out of range at output")

endmodule

### sv/thresholded_pixel_ratio.sv
// channel   | dir | transaction payload
// in_pix    | in  | pixel_num[15:0], pixel_den[15:0]
// out_res   | out | ratio[15:0]
// cfg_*     | in  | cfg_index 0 threshold[15:0], 1 gain[39:0] (U24.16)
//
// one pixel pair accepted per cycle while in_pix.ready is high; each result passes through
// two front stages for multiply and rounding add, then four divider stages of four bits
// every stage has its own valid bit, so bubbles close up under an output stall
// in_pix.ready falls only when all six stages hold a result
// synchronous active-low reset empties the pipeline and sets threshold 1, gain 1.0
// top level: config registers, front stages and divider
// depends on tpr_pkg, tpr_in_if, tpr_out_if, tpr_front, tpr_div and the defines header
`include "thresholded_pixel_ratio_defines.svh"

module thresholded_pixel_ratio #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tpr_in_if.sink                              in_pix,
  tpr_out_if.source                           out_res,
  input  logic                                cfg_we,
  input  logic [tpr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tpr_pkg::GAIN_BITS-1:0]       cfg_wdata
);
  import tpr_pkg::*;

  logic [THRESH_BITS-1:0] threshold_r;
  logic [GAIN_BITS-1:0]   gain_r;

  logic                  mid_valid, mid_ready;
  tpr_flags_t            mid_flags;
  logic [PIXEL_BITS-1:0] mid_rem;
  logic [RATIO_BITS-1:0] mid_lo;
  logic [PIXEL_BITS-1:0] mid_den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RESET;
      gain_r      <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_r <= cfg_wdata[THRESH_BITS-1:0];
        CFG_GAIN:      gain_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpr_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .gain      (gain_r),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .pixel_num (in_pix.pixel_num[PIXEL_BITS-1:0]),
    .pixel_den (in_pix.pixel_den[PIXEL_BITS-1:0]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_flags (mid_flags),
    .out_rem   (mid_rem),
    .out_lo    (mid_lo),
    .out_den   (mid_den)
  );

  tpr_div #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_flags  (mid_flags),
    .in_rem    (mid_rem),
    .in_lo     (mid_lo),
    .in_den    (mid_den),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_ratio (out_res.ratio)
  );

  `TPR_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_res.valid, in_pix.ready, "input stalled while output stage empty")

endmodule

### test/testbench.sv
// self-checking testbench for thresholded_pixel_ratio: directed, back-pressure and random traffic
// an in-line ratio predictor checks every result transaction in order
// depends on tpr_pkg, tpr_in_if, tpr_out_if and the thresholded_pixel_ratio rtl
module testbench;
  import tpr_pkg::*;

  localparam int          PIX_BITS    = 16;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_SLACK = 12;
  localparam int          STAGES      = 2 + DIV_STAGES;
  localparam logic [63:0] PIX_MASK    = (64'd1 << PIX_BITS) - 64'd1;
  localparam logic [63:0] GAIN_MAX    = (64'd1 << GAIN_BITS) - 64'd1;
  localparam logic [63:0] HALF_LSB    = 64'd32768;
  localparam logic [63:0] ONE_FIX     = 64'd65536;
  localparam logic [63:0] RATIO_MAX   = 64'd65535;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [GAIN_BITS-1:0]      cfg_wdata;

  tpr_in_if  in_ch ();
  tpr_out_if out_ch ();

  thresholded_pixel_ratio #(
    .PIXEL_BITS(PIX_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [THRESH_BITS-1:0] threshold_setting = THRESH_RESET;
  logic [GAIN_BITS-1:0]   gain_setting      = GAIN_RESET;
  logic [RATIO_BITS-1:0]  pending_ratios[$];
  int                     failure_count = 0;
  int                     cycle_count   = 0;
  int                     hold_cycles   = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [RATIO_BITS-1:0] predict_ratio(input logic [FIELD_BITS-1:0] num,
                                                          input logic [FIELD_BITS-1:0] den);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    a = 64'(num) & PIX_MASK;
    b = 64'(den) & PIX_MASK;
    if (a < 64'(threshold_setting) || b < 64'(threshold_setting)) begin
      q = 64'd0;
    end else if (b == 64'd0) begin
      q = RATIO_MAX;
    end else begin
      q = (64'(gain_setting) * a + b * HALF_LSB) / (b * ONE_FIX);
      if (q > RATIO_MAX) q = RATIO_MAX;
    end
    return q[RATIO_BITS-1:0];
  endfunction

  // scoreboard, cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_ratios.push_back(predict_ratio(in_ch.pixel_num, in_ch.pixel_den));
      if (out_ch.valid && out_ch.ready) begin
        if (pending_ratios.size() == 0) begin
          if (failure_count < 10) $display("unexpected ratio transaction: %0d", out_ch.ratio);
          failure_count++;
        end else begin
          if (out_ch.ratio !== pending_ratios[0]) begin
            if (failure_count < 10)
              $display("ratio mismatch: expected %0d got %0d", pending_ratios[0], out_ch.ratio);
            failure_count++;
          end
          void'(pending_ratios.pop_front());
        end
      end
    end
  end

  // result side ready, with forced hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_pixels(input logic [FIELD_BITS-1:0] num, input logic [FIELD_BITS-1:0] den);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pixel_num <= num;
    in_ch.pixel_den <= den;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_ratios.size() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) threshold_setting = value[THRESH_BITS-1:0];
    else gain_setting = value;
    @(posedge clk);
  endtask

  function automatic logic [FIELD_BITS-1:0] rand_pixel();
    int t;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: begin
        t = int'(threshold_setting) + int'($urandom_range(2)) - 1;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return FIELD_BITS'(t);
      end
      3, 4: return FIELD_BITS'($urandom_range(255));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [THRESH_BITS-1:0] rand_threshold();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return THRESH_BITS'($urandom);
      default: return THRESH_BITS'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_gain();
    logic [63:0] g;
    logic [63:0] peak;
    case ($urandom_range(5))
      0: g = {$urandom, $urandom} & GAIN_MAX;
      1: g = 64'($urandom_range(262144));
      default: begin
        peak = 64'($urandom_range(65535, (threshold_setting == 0) ? 1 : int'(threshold_setting)));
        g = (64'(threshold_setting) * RATIO_MAX * ONE_FIX) / peak;
      end
    endcase
    if (g > GAIN_MAX) g = GAIN_MAX;
    return g[GAIN_BITS-1:0];
  endfunction

  task automatic test_reset_defaults();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    send_pixels(16'd0, 16'd0);
    send_pixels(16'd0, 16'd9);
    send_pixels(16'd9, 16'd0);
    send_pixels(16'd5, 16'd5);
    send_pixels(16'd1, 16'd2);
    send_pixels(16'd3, 16'd2);
    send_pixels(16'hFFFF, 16'd1);
    send_pixels(16'd1, 16'hFFFF);
    send_pixels(16'hFFFF, 16'hFFFF);
    send_pixels(16'hAAAA, 16'h5555);
    wait_results_drained();
  endtask

  task automatic test_threshold_zero();
    write_reg(CFG_THRESHOLD, '0);
    send_pixels(16'd0, 16'd0);
    send_pixels(16'd0, 16'd5);
    wait_results_drained();
    write_reg(CFG_GAIN, '0);
    send_pixels(16'd100, 16'd3);
    send_pixels(16'hFFFF, 16'd1);
    wait_results_drained();
  endtask

  task automatic test_gain_extremes();
    write_reg(CFG_THRESHOLD, '1);
    write_reg(CFG_GAIN, GAIN_MAX[GAIN_BITS-1:0]);
    send_pixels(16'hFFFF, 16'hFFFF);
    send_pixels(16'hFFFE, 16'hFFFF);
    send_pixels(16'hFFFF, 16'hFFFE);
    wait_results_drained();
  endtask

  task automatic test_half_rounding();
    write_reg(CFG_THRESHOLD, 40'd1);
    write_reg(CFG_GAIN, 40'd32768);
    send_pixels(16'd1, 16'd1);
    send_pixels(16'd3, 16'd4);
    send_pixels(16'd5, 16'd4);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_THRESHOLD, 40'd1);
    write_reg(CFG_GAIN, 40'd196608);
    hold_cycles = 60 + STAGES;
    repeat (30) send_pixels(rand_pixel(), rand_pixel());
    wait_results_drained();
    repeat (10) send_pixels(rand_pixel(), rand_pixel());
    wait_results_drained();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      write_reg(CFG_THRESHOLD, 40'(rand_threshold()));
      write_reg(CFG_GAIN, rand_gain());
      repeat (50) send_pixels(rand_pixel(), rand_pixel());
      wait_results_drained();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(18, 87);
    run_random_phase(87, 18);
    run_random_phase(0, 0);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.pixel_num <= '0;
    in_ch.pixel_den <= '0;
    out_ch.ready    <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_THRESHOLD;
    cfg_wdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_zero();
    test_gain_extremes();
    test_half_rounding();
    test_backpressure();
    test_random_traffic();

    if (failure_count == 0 && pending_ratios.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/tpr_pkg.sv
sv/tpr_in_if.sv
sv/tpr_out_if.sv
sv/tpr_front.sv
sv/tpr_div.sv
sv/thresholded_pixel_ratio.sv
test/testbench.sv
